// ===== rtl/atsc_pkg.sv =====
`timescale 1ns / 1ps
package atsc_pkg;

    localparam int LANES      = 8;
    localparam int LANE_W     = 3;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int KGAIN_W    = 17;
    localparam int CNT_W      = 6;
    localparam int DIVD_W     = 49;
    localparam int ACC_W      = 65;

    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIVD_W);
    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(DATA_W);

    localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] U32_MAX = 32'hFFFF_FFFF;

    // register reset values
    localparam logic [DATA_W-1:0]  RST_BASE_MIN  = 32'h0001_0000;
    localparam logic [DATA_W-1:0]  RST_BASE_MAX  = 32'h0001_0000;
    localparam logic [DATA_W-1:0]  RST_TAU_GAIN  = 32'h0001_0000;
    localparam logic [DATA_W-1:0]  RST_GROWTH    = 32'h0000_0000;
    localparam logic [DATA_W-1:0]  RST_KNEE_LVL  = 32'hFFFF_FFFF;
    localparam logic [KGAIN_W-1:0] RST_KNEE_GAIN = 17'h1_0000;
    localparam logic [DATA_W-1:0]  RST_RESET_LVL = 32'h0000_0000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAU_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROWTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KNEE_LVL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KNEE_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LVL = 3'd6;

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_LOAD    = 15'b000000000000010,
        S_DROPDIV = 15'b000000000000100,
        S_DROPCHK = 15'b000000000001000,
        S_TAUDIV  = 15'b000000000010000,
        S_TAUCHK  = 15'b000000000100000,
        S_GAINMUL = 15'b000000001000000,
        S_CLAMP   = 15'b000000010000000,
        S_GROWMUL = 15'b000000100000000,
        S_GROWCHK = 15'b000001000000000,
        S_KNEE    = 15'b000010000000000,
        S_KMUL    = 15'b000100000000000,
        S_KCHK    = 15'b001000000000000,
        S_FIN     = 15'b010000000000000,
        S_OUT     = 15'b100000000000000
    } t_state;

endpackage

// ===== rtl/adaptive_time_step_controller.sv =====
`timescale 1ns / 1ps
// Handles one item at a time: s_tready is high only while idle, so no new energy
// is taken until the last step has been loaded into the output register.
// An unchanged energy skips both divisions and the gain and growth multiplies;
// a bit-serial divider and a shift-add multiplier do the arithmetic.
// Reset (i_rst_n low, synchronous) restores register defaults, clears each
// lane's energy and sets its step and limit to the default base values.
module adaptive_time_step_controller import atsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // [31:0] energy
    input  logic [LANE_W-1:0]    s_tuser,   // [2:0] lane
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // [31:0] step_out
    output logic [LANE_W-1:0]    m_tuser    // [2:0] lane_out
);

    t_state r_state;

    logic [DATA_W-1:0]  r_base_min, r_base_max, r_tau_gain, r_growth, r_knee_lvl, r_reset_lvl;
    logic [KGAIN_W-1:0] r_knee_gain;

    logic [DATA_W-1:0] r_prev [LANES];
    logic [DATA_W-1:0] r_stp  [LANES];
    logic [DATA_W-1:0] r_lim  [LANES];

    logic [LANE_W-1:0] r_lane;
    logic [DATA_W-1:0] r_enew, r_eold, r_step, r_oldlim, r_newlim, r_drop, r_res;
    logic              r_neg;

    // serial divider and multiplier
    logic [DATA_W-1:0] r_rem, r_dvs;
    logic [DIVD_W-1:0] r_dq;
    logic [ACC_W-1:0]  r_acc;
    logic [DATA_W:0]   r_ma;
    logic [DATA_W-1:0] r_mb;
    logic [CNT_W-1:0]  r_cnt;

    logic                r_ovalid;
    logic [DATA_W-1:0]   r_ostep;
    logic [LANE_W-1:0]   r_olane;

    logic [DATA_W-1:0]   w_eold, w_s, w_m;
    logic signed [DATA_W:0] w_diff;
    logic [DATA_W:0]     w_absdiff;
    logic [DATA_W:0]     w_trial, w_sub;
    logic                w_ge;
    logic [ACC_W-1:0]    w_acc_nx;
    logic [DATA_W-1:0]   w_dropsat, w_tausat;
    logic                w_rst_cond;
    logic [DIVD_W:0]     w_growsum;
    logic signed [DATA_W:0] w_delta;
    logic signed [DIVD_W+1:0] w_klim;
    logic [DATA_W-1:0]   w_klimsat;

    always_comb begin
        w_eold    = r_prev[r_lane];
        w_s       = r_stp[r_lane];
        w_m       = r_lim[r_lane];
        w_diff    = $signed({w_eold[DATA_W-1], w_eold}) - $signed({r_enew[DATA_W-1], r_enew});
        w_absdiff = w_diff[DATA_W] ? (DATA_W+1)'(-w_diff) : (DATA_W+1)'(w_diff);

        // one restoring divide step
        w_trial = {r_rem, r_dq[DIVD_W-1]};
        w_ge    = w_trial >= {1'b0, r_dvs};
        w_sub   = w_trial - {1'b0, r_dvs};

        // one shift-add multiply step, multiplier taken MSB first
        w_acc_nx = {r_acc[ACC_W-2:0], 1'b0} + (r_mb[DATA_W-1] ? ACC_W'(r_ma) : ACC_W'(0));

        // saturate drop quotient to signed 32 bits
        if (!r_neg)
            w_dropsat = (r_dq > DIVD_W'(S32_MAX)) ? S32_MAX : r_dq[DATA_W-1:0];
        else
            w_dropsat = (r_dq > DIVD_W'(S32_MIN)) ? S32_MIN : (~r_dq[DATA_W-1:0] + 1'b1);

        w_tausat = (r_dq > DIVD_W'(S32_MAX)) ? S32_MAX : r_dq[DATA_W-1:0];

        w_rst_cond = ($signed(r_drop) < $signed(r_reset_lvl)) ||
                     r_eold[DATA_W-1] || (r_eold == '0) ||
                     r_enew[DATA_W-1] || (r_enew == '0);

        w_growsum = (DIVD_W+1)'(r_oldlim) + (DIVD_W+1)'(r_acc[ACC_W-1:16]);

        w_delta = $signed({1'b0, r_newlim}) - $signed({1'b0, r_oldlim});

        if (r_neg)
            w_klim = $signed((DIVD_W+2)'(r_oldlim)) - $signed((DIVD_W+2)'(r_acc[ACC_W-1:16]));
        else
            w_klim = $signed((DIVD_W+2)'(r_oldlim)) + $signed((DIVD_W+2)'(r_acc[ACC_W-1:16]));

        if (w_klim[DIVD_W+1])
            w_klimsat = '0;
        else if (w_klim[DIVD_W:DATA_W] != '0)
            w_klimsat = U32_MAX;
        else
            w_klimsat = w_klim[DATA_W-1:0];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_min  <= RST_BASE_MIN;
            r_base_max  <= RST_BASE_MAX;
            r_tau_gain  <= RST_TAU_GAIN;
            r_growth    <= RST_GROWTH;
            r_knee_lvl  <= RST_KNEE_LVL;
            r_knee_gain <= RST_KNEE_GAIN;
            r_reset_lvl <= RST_RESET_LVL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_MIN:  r_base_min  <= i_cfg_data;
                CFG_BASE_MAX:  r_base_max  <= i_cfg_data;
                CFG_TAU_GAIN:  r_tau_gain  <= i_cfg_data;
                CFG_GROWTH:    r_growth    <= i_cfg_data;
                CFG_KNEE_LVL:  r_knee_lvl  <= i_cfg_data;
                CFG_KNEE_GAIN: r_knee_gain <= i_cfg_data[KGAIN_W-1:0];
                CFG_RESET_LVL: r_reset_lvl <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // lane state: written once per item at the end of the update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                r_prev[i] <= '0;
                r_stp[i]  <= RST_BASE_MIN;
                r_lim[i]  <= RST_BASE_MAX;
            end
        end else if (r_state == S_FIN) begin
            r_prev[r_lane] <= r_enew;
            r_stp[r_lane]  <= r_step;
            r_lim[r_lane]  <= r_newlim;
        end
    end

    // update sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // load the output register, or drop it once its transfer completes
            if (r_state == S_OUT && (!r_ovalid || m_tready))
                r_ovalid <= 1'b1;
            else if (r_ovalid && m_tready)
                r_ovalid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_lane  <= s_tuser;
                        r_enew  <= s_tdata;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_eold   <= w_eold;
                    r_step   <= w_s;
                    r_oldlim <= w_m;
                    r_newlim <= w_m;
                    r_neg    <= w_diff[DATA_W];
                    if (r_enew == w_eold) begin
                        r_state <= S_KNEE;
                    end else if (w_s == '0) begin
                        r_drop  <= w_diff[DATA_W] ? S32_MIN : S32_MAX;
                        r_state <= S_DROPCHK;
                    end else begin
                        r_dq    <= {w_absdiff, 16'b0};
                        r_rem   <= '0;
                        r_dvs   <= w_s;
                        r_cnt   <= DIV_STEPS;
                        r_state <= S_DROPDIV;
                    end
                end
                S_DROPDIV, S_TAUDIV: begin
                    r_rem <= w_ge ? w_sub[DATA_W-1:0] : w_trial[DATA_W-1:0];
                    r_dq  <= {r_dq[DIVD_W-2:0], w_ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1))
                        r_state <= (r_state == S_DROPDIV) ? S_DROPCHK : S_TAUCHK;
                    if (r_cnt == CNT_W'(1) && r_state == S_DROPDIV)
                        r_drop <= r_drop;
                end
                S_DROPCHK: begin
                    // the drop comes from the divider unless the step was zero
                    if (r_cnt == '0 && r_dvs != '0 && r_state == S_DROPCHK && r_step != '0)
                        r_drop <= w_dropsat;
                    r_state <= S_TAUCHK;
                    r_cnt   <= CNT_W'(63);
                end
                S_TAUCHK: begin
                    if (r_cnt == CNT_W'(63)) begin
                        // test reset and drop sign; launch tau divide if drop > 0
                        if (w_rst_cond) begin
                            r_step   <= r_base_min;
                            r_newlim <= r_base_max;
                            r_state  <= S_KNEE;
                        end else if (r_drop[DATA_W-1]) begin
                            r_step  <= '0;
                            r_state <= S_CLAMP;
                        end else if (r_drop == '0) begin
                            r_ma    <= {1'b0, r_tau_gain};
                            r_mb    <= S32_MAX;
                            r_acc   <= '0;
                            r_cnt   <= MUL_STEPS;
                            r_state <= S_GAINMUL;
                        end else begin
                            r_dq    <= {2'b0, r_eold[DATA_W-2:0], 16'b0};
                            r_rem   <= '0;
                            r_dvs   <= r_drop;
                            r_cnt   <= DIV_STEPS;
                            r_state <= S_TAUDIV;
                        end
                    end else begin
                        // tau quotient is ready: start the gain product
                        r_ma    <= {1'b0, r_tau_gain};
                        r_mb    <= w_tausat;
                        r_acc   <= '0;
                        r_cnt   <= MUL_STEPS;
                        r_state <= S_GAINMUL;
                    end
                end
                S_GAINMUL, S_GROWMUL, S_KMUL: begin
                    r_acc <= w_acc_nx;
                    r_mb  <= {r_mb[DATA_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        case (r_state)
                            S_GAINMUL: r_state <= S_CLAMP;
                            S_GROWMUL: r_state <= S_GROWCHK;
                            default:   r_state <= S_KCHK;
                        endcase
                    end
                end
                S_CLAMP: begin
                    logic [DATA_W-1:0] v_step;
                    if (r_step == '0 && r_drop[DATA_W-1])
                        v_step = '0;
                    else if (r_acc[ACC_W-1:48] != '0)
                        v_step = U32_MAX;
                    else
                        v_step = r_acc[47:16];
                    if (v_step >= r_oldlim) begin
                        r_step  <= r_oldlim;
                        r_ma    <= {1'b0, r_oldlim};
                        r_mb    <= r_growth;
                        r_acc   <= '0;
                        r_cnt   <= MUL_STEPS;
                        r_state <= S_GROWMUL;
                    end else begin
                        r_step   <= v_step;
                        r_newlim <= r_oldlim;
                        r_state  <= S_KNEE;
                    end
                end
                S_GROWCHK: begin
                    r_newlim <= (w_growsum[DIVD_W:DATA_W] != '0) ? U32_MAX : w_growsum[DATA_W-1:0];
                    r_state  <= S_KNEE;
                end
                S_KNEE: begin
                    if (r_newlim > r_knee_lvl) begin
                        r_neg   <= w_delta[DATA_W];
                        r_ma    <= w_delta[DATA_W] ? (DATA_W+1)'(-w_delta)
                                                   : (DATA_W+1)'(w_delta);
                        r_mb    <= DATA_W'(r_knee_gain);
                        r_acc   <= '0;
                        r_cnt   <= MUL_STEPS;
                        r_state <= S_KMUL;
                    end else begin
                        r_res   <= r_step;
                        r_state <= S_FIN;
                    end
                end
                S_KCHK: begin
                    r_newlim <= w_klimsat;
                    r_res    <= (w_klimsat < r_step) ? w_klimsat : r_step;
                    r_state  <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold the result until the output register is free
                    if (!r_ovalid || m_tready) begin
                        r_ostep  <= r_res;
                        r_olane  <= r_lane;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_ostep;
    assign m_tuser  = r_olane;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import atsc_pkg::*;

    typedef struct {
        logic [LANE_W-1:0] lane;
        logic [DATA_W-1:0] energy;
    } t_energy_upd;

    typedef struct {
        logic [LANE_W-1:0] lane;
        logic [DATA_W-1:0] step;
    } t_lane_step;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0]    i_cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;   // [31:0] energy
    logic [LANE_W-1:0]    s_tuser;   // [2:0] lane
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;   // [31:0] step_out
    logic [LANE_W-1:0]    m_tuser;   // [2:0] lane_out

    adaptive_time_step_controller i_dut (.*);

    // pending energy updates and expected lane steps
    t_energy_upd upd_q[$];
    t_lane_step  step_q[$];

    // predictor copy of registers and per-lane state
    logic [DATA_W-1:0]  min_step, max_step, gain_tau, grow, knee_lvl, rst_lvl;
    logic [KGAIN_W-1:0] knee_k;
    logic [DATA_W-1:0]  lane_energy [LANES];
    logic [DATA_W-1:0]  cur_step    [LANES];
    logic [DATA_W-1:0]  cur_limit   [LANES];

    // generator view of each lane's last energy
    logic [DATA_W-1:0] gen_energy [LANES];

    bit     idle_on;
    bit     rx_stall_req;
    bit     rx_stall_done;
    int     rx_stall;
    int     tx_gap;
    int     rx_gap;
    int     errors;
    longint cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // advance one lane and return its capped step
    function automatic logic [DATA_W-1:0] advance_lane(input logic [LANE_W-1:0] ln,
                                                       input logic [DATA_W-1:0] e_raw);
        longint e_new, e_old, stp, old_lim, new_lim, diff, drop, tau, dlt, mag;
        longint unsigned prod, g;
        logic [DATA_W-1:0] res;
        e_new   = longint'(signed'(e_raw));
        e_old   = longint'(signed'(lane_energy[ln]));
        stp     = longint'(cur_step[ln]);
        old_lim = longint'(cur_limit[ln]);
        new_lim = old_lim;
        if (e_new != e_old) begin
            diff = e_old - e_new;
            if (stp == 0)
                drop = diff > 0 ? 64'sd2147483647 : -64'sd2147483648;
            else
                drop = sat((diff * 65536) / stp, -64'sd2147483648, 64'sd2147483647);
            if (drop < longint'(signed'(rst_lvl)) || e_old <= 0 || e_new <= 0) begin
                stp     = longint'(min_step);
                new_lim = longint'(max_step);
            end else begin
                if (drop == 0)
                    tau = 64'sd2147483647;
                else
                    tau = sat((e_old * 65536) / drop, -64'sd2147483648, 64'sd2147483647);
                if (tau <= 0) begin
                    stp = 0;
                end else begin
                    prod = (longint'(gain_tau) * tau) >> 16;
                    stp  = prod > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : longint'(prod);
                end
                if (stp >= old_lim) begin
                    g       = (longint'(old_lim) * longint'(grow)) >> 16;
                    stp     = old_lim;
                    new_lim = sat(old_lim + longint'(g), 0, 64'hFFFF_FFFF);
                end
            end
        end
        res = stp[31:0];
        // damp limit changes above the knee
        if (new_lim > longint'(knee_lvl)) begin
            dlt     = new_lim - old_lim;
            mag     = dlt < 0 ? -dlt : dlt;
            mag     = (mag * longint'(knee_k)) / 65536;
            new_lim = sat(old_lim + (dlt < 0 ? -mag : mag), 0, 64'hFFFF_FFFF);
            if (new_lim < stp)
                res = new_lim[31:0];
        end
        lane_energy[ln] = e_raw;
        cur_step[ln]    = stp[31:0];
        cur_limit[ln]   = new_lim[31:0];
        return res;
    endfunction

    // sender: present queued updates, predict on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            tx_gap   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                step_q.push_back('{upd_q[0].lane, advance_lane(upd_q[0].lane, upd_q[0].energy)});
                void'(upd_q.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                // hold the current item
            end else if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (upd_q.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                tx_gap = $urandom_range(1, 19) - 1;
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= upd_q[0].energy;
                s_tuser  <= upd_q[0].lane;
            end
        end
    end

    // receiver: check each transfer, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_gap   = 0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (step_q.size() == 0) begin
                    $display("%0t: unexpected step lane %0d step %h", $time, m_tuser, m_tdata);
                    errors++;
                end else begin
                    if (m_tuser !== step_q[0].lane) begin
                        $display("%0t: lane expected %0d actual %0d",
                                 $time, step_q[0].lane, m_tuser);
                        errors++;
                    end
                    if (m_tdata !== step_q[0].step) begin
                        $display("%0t: step expected %h actual %h",
                                 $time, step_q[0].step, m_tdata);
                        errors++;
                    end
                    void'(step_q.pop_front());
                end
            end
            if (rx_stall_req && !rx_stall_done) begin
                rx_stall_done = 1'b1;
                rx_stall      = 1500;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                rx_gap = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_BASE_MIN:  min_step = val;
            CFG_BASE_MAX:  max_step = val;
            CFG_TAU_GAIN:  gain_tau = val;
            CFG_GROWTH:    grow     = val;
            CFG_KNEE_LVL:  knee_lvl = val;
            CFG_KNEE_GAIN: knee_k   = val[KGAIN_W-1:0];
            CFG_RESET_LVL: rst_lvl  = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all(input logic [DATA_W-1:0] bmin, bmax, tg, gr, kl, kg, rl);
        cfg_write(CFG_BASE_MIN, bmin);
        cfg_write(CFG_BASE_MAX, bmax);
        cfg_write(CFG_TAU_GAIN, tg);
        cfg_write(CFG_GROWTH, gr);
        cfg_write(CFG_KNEE_LVL, kl);
        cfg_write(CFG_KNEE_GAIN, kg);
        cfg_write(CFG_RESET_LVL, rl);
    endtask

    task automatic push_upd(input logic [LANE_W-1:0] ln, input logic [DATA_W-1:0] e);
        upd_q.push_back('{ln, e});
        gen_energy[ln] = e;
    endtask

    task automatic wait_drained();
        while (upd_q.size() != 0 || s_tvalid || step_q.size() != 0)
            @(posedge i_clk);
    endtask

    // mostly smooth energy decay per lane, some repeats and raw noise
    task automatic random_updates(input int n);
        logic [LANE_W-1:0] ln;
        logic [DATA_W-1:0] e;
        int                sel;
        for (int k = 0; k < n; k++) begin
            ln  = LANE_W'($urandom_range(0, LANES - 1));
            sel = $urandom_range(0, 99);
            e   = gen_energy[ln];
            if (sel < 10) begin
                e = $urandom();
            end else if (sel < 20) begin
                // repeat the last energy
            end else if (sel < 28 || signed'(e) <= 0) begin
                e = $urandom_range(1, 32'h7FFF_FFFF);
            end else if (sel < 36) begin
                e = e + (e >> $urandom_range(1, 12));
            end else begin
                e = e - (e >> $urandom_range(1, 16)) - $urandom_range(0, 3);
            end
            push_upd(ln, e);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        idle_on    = 1'b1;
        errors     = 0;
        cycles     = 0;
        min_step = RST_BASE_MIN;  max_step = RST_BASE_MAX;  gain_tau = RST_TAU_GAIN;
        grow     = RST_GROWTH;    knee_lvl = RST_KNEE_LVL;  knee_k   = RST_KNEE_GAIN;
        rst_lvl  = RST_RESET_LVL;
        for (int i = 0; i < LANES; i++) begin
            lane_energy[i] = '0;
            cur_step[i]    = RST_BASE_MIN;
            cur_limit[i]   = RST_BASE_MAX;
            gen_energy[i]  = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, unchanged energy, sign cases, clamp and growth
        set_all(32'h0001_0000, 32'h0004_0000, 32'h0001_0000, 32'h0000_8000,
                32'h0008_0000, 32'h0000_8000, 32'h0000_0000);
        push_upd(0, 32'h000A_0000);
        push_upd(0, 32'h000A_0000);
        push_upd(0, 32'h0009_0000);
        push_upd(0, 32'h0008_0000);
        push_upd(0, 32'h0007_0000);
        push_upd(0, 32'h0006_0000);
        push_upd(0, 32'h0005_8000);
        push_upd(0, 32'h0005_7FFF);
        push_upd(7, 32'h7FFF_FFFF);
        push_upd(7, 32'h7FFF_FFFE);
        push_upd(7, 32'h0000_0001);
        push_upd(7, 32'h8000_0000);
        push_upd(7, 32'h0000_0000);
        push_upd(7, 32'hFFFF_FFFF);
        push_upd(3, 32'h0000_0010);
        push_upd(3, 32'h0000_0020);
        push_upd(3, 32'h0000_001F);
        push_upd(5, 32'h0100_0000);
        push_upd(5, 32'h00FF_FFFF);
        push_upd(5, 32'h00FF_FFFE);
        wait_drained();

        // zero step: drop saturates, zero drop gives largest tau
        set_all(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'h0000_0000, 32'h0001_0000, 32'h8000_0000);
        push_upd(1, 32'hFFFF_0000);
        push_upd(1, 32'h0010_0000);
        push_upd(1, 32'h000F_0000);
        push_upd(1, 32'h000E_FFFF);
        random_updates(120);
        wait_drained();

        // long receiver stall while the sender keeps offering
        rx_stall_req = 1'b1;
        set_all($urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom_range(0, 65536), $urandom());
        random_updates(130);
        wait_drained();

        // all registers at zero
        set_all(0, 0, 0, 0, 0, 0, 0);
        random_updates(120);
        wait_drained();

        // registers at their largest but knee gain at one, most negative reset level
        set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000);
        random_updates(120);
        wait_drained();

        // largest reset level: every change resets unless its drop saturates
        set_all(32'h0000_4000, 32'h0010_0000, 32'h0002_0000, 32'h0001_0000,
                32'h0004_0000, 32'h0000_0000, 32'h7FFF_FFFF);
        random_updates(80);
        wait_drained();

        // moderate settings with a low knee
        for (int p = 0; p < 4; p++) begin
            set_all($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0100_0000),
                    $urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0002_0000),
                    $urandom_range(0, 32'h0080_0000), $urandom_range(0, 65536),
                    $urandom_range(0, 32'h0001_0000) - 32'h0000_8000);
            random_updates(110);
            wait_drained();
        end

        // closing stretch without idling
        idle_on = 1'b0;
        set_all(32'h0000_8000, 32'h0020_0000, 32'h0001_8000, 32'h0000_4000,
                32'h0010_0000, 32'h0000_C000, 32'hFFFF_0000);
        random_updates(100);
        wait_drained();
        repeat (250) @(posedge i_clk);

        if (errors == 0 && step_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
